>>> design/vrd_pkg.sv
package vrd_pkg;

    typedef enum logic [1:0] {
        ACT_IGNORE = 2'd0,
        ACT_START  = 2'd1,
        ACT_APPEND = 2'd2,
        ACT_RESET  = 2'd3
    } act_t;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_MORE     = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // payload descriptor bit positions
    localparam int DESC_X = 7;
    localparam int DESC_N = 5;
    localparam int DESC_S = 4;
    localparam int EXT_I  = 7;
    localparam int EXT_L  = 6;
    localparam int EXT_T  = 5;
    localparam int EXT_K  = 4;
    localparam int PID_M  = 7;

    localparam int STATUS_W = 2;
    localparam int LEN_W    = 17;

endpackage

>>> design/vp8_rtp_depacketizer_top.sv
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | kind, data_byte, packet_first, packet_last,
//         |          |           | rtp_timestamp, rtp_marker, read_index
// out     | out_valid| out_stall | status, frame_bytes, keyframe, read_data
//
// one request per cycle on both sides while no stall holds them; a result passes through
// the frame store read and middle stage register, then the output register
// only back-pressure from out_stall limits the rate
// reset clears all frame state; the frame store holds its contents and needs no clearing
// out_stall holds the output register, then the middle stage, then in_stall rises
module vp8_rtp_depacketizer_top
    import vrd_pkg::*;
#(
    parameter int FRAME_BYTES  = 65536,
    parameter int PACKET_BYTES = 2048
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                kind,
    input  logic [7:0]          data_byte,
    input  logic                packet_first,
    input  logic                packet_last,
    input  logic [31:0]         rtp_timestamp,
    input  logic                rtp_marker,
    input  logic [15:0]         read_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [LEN_W-1:0]    frame_bytes,
    output logic                keyframe,
    output logic [7:0]          read_data
);

    localparam int AW = $clog2(FRAME_BYTES);
    localparam int LW = $clog2(FRAME_BYTES + 1);
    localparam int PW = $clog2(PACKET_BYTES + 1);
    localparam int IW = ((LW > PW) ? LW : PW) + 1;
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;

    logic [7:0] mem [FRAME_BYTES];
    logic [7:0] mem_q;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;
    logic          mem_re;

    logic [LW-1:0] committed_reg, committed_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic          collecting_reg, collecting_next;
    logic [31:0]   frame_ts_reg, frame_ts_next;
    logic [31:0]   pend_ts_reg, pend_ts_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    desc_reg, desc_next;
    logic [7:0]    ext_reg, ext_next;
    logic [2:0]    dlen_reg, dlen_next;
    act_t          act_reg, act_next;
    logic          ovf_reg, ovf_next;
    logic          in_pkt_reg, in_pkt_next;
    logic          too_long_reg, too_long_next;

    logic                p1_valid_reg, p1_valid_next;
    logic [STATUS_W-1:0] p1_status_reg;
    logic [LEN_W-1:0]    p1_len_reg;
    logic                p1_key_reg;
    logic                p1_rdok_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_key_reg;
    logic [7:0]          out_rd_reg;

    logic                out_load;
    logic                in_fire;
    logic                take;
    logic                read_ok;
    logic                res_valid;
    logic [STATUS_W-1:0] res_status;
    logic [LEN_W-1:0]    res_len;
    logic                res_key;
    logic                res_rdok;

    logic [PW-1:0] c_pos;
    logic [2:0]    c_dlen;
    logic [7:0]    c_ext;
    act_t          c_act;
    act_t          new_act;
    logic [LW-1:0] base;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] fill_sum;

    assign out_load = !out_valid_reg || !out_stall;
    assign in_stall = p1_valid_reg && !out_load;
    assign in_fire  = in_valid && !in_stall;

    assign read_ok = (CW'(read_index) < CW'(committed_reg))
                  && (CW'(read_index) < CW'(FRAME_BYTES));
    assign mem_ra  = AW'(CW'(read_index));
    assign mem_re  = in_fire && (kind == KIND_READ) && read_ok;
    assign take    = in_fire && (kind == KIND_BYTE) && (packet_first || in_pkt_reg);

    always_comb
    begin
        if (data_byte[DESC_S])
            new_act = ACT_START;
        else if (collecting_reg && (rtp_timestamp != frame_ts_reg))
            new_act = ACT_RESET;
        else if (!collecting_reg)
            new_act = ACT_IGNORE;
        else
            new_act = ACT_APPEND;
    end

    always_comb
    begin
        c_pos  = packet_first ? '0 : pos_reg;
        c_dlen = packet_first ? 3'd1 : dlen_reg;
        c_ext  = packet_first ? 8'd0 : ext_reg;
        c_act  = packet_first ? new_act : act_reg;
        base   = (c_act == ACT_START) ? '0 : fill_reg;
        wr_idx = IW'(base) + IW'(c_pos - PW'(c_dlen));
    end

    always_comb
    begin
        committed_next  = committed_reg;
        fill_next       = fill_reg;
        collecting_next = collecting_reg;
        frame_ts_next   = frame_ts_reg;
        pend_ts_next    = pend_ts_reg;
        pos_next        = pos_reg;
        desc_next       = desc_reg;
        ext_next        = ext_reg;
        dlen_next       = dlen_reg;
        act_next        = act_reg;
        ovf_next        = ovf_reg;
        in_pkt_next     = in_pkt_reg;
        too_long_next   = too_long_reg;
        mem_we          = 1'b0;
        mem_wa          = wr_idx[AW-1:0];
        fill_sum        = '0;
        res_valid       = 1'b0;
        res_status      = ST_MORE;
        res_len         = '0;
        res_key         = 1'b0;
        res_rdok        = 1'b0;

        if (in_fire && (kind == KIND_READ))
        begin
            res_valid  = 1'b1;
            res_status = read_ok ? ST_DONE : ST_INVALID;
            res_rdok   = read_ok;
        end

        if (take)
        begin
            if (packet_first)
            begin
                in_pkt_next   = 1'b1;
                too_long_next = 1'b0;
                ovf_next      = 1'b0;
                pos_next      = '0;
                dlen_next     = 3'd1;
                ext_next      = 8'd0;
                pend_ts_next  = rtp_timestamp;
                act_next      = new_act;
            end

            if (32'(c_pos) >= 32'(PACKET_BYTES))
                too_long_next = 1'b1;
            else
            begin
                pos_next = c_pos + PW'(1);
                if (c_pos < PW'(c_dlen))
                begin
                    // descriptor bytes
                    if (c_pos == '0)
                    begin
                        desc_next = data_byte;
                        dlen_next = data_byte[DESC_X] ? 3'd2 : 3'd1;
                    end
                    else if (c_pos == PW'(1))
                    begin
                        ext_next  = data_byte;
                        dlen_next = 3'd2 + {2'b0, data_byte[EXT_I]} + {2'b0, data_byte[EXT_L]}
                                  + {2'b0, data_byte[EXT_T] | data_byte[EXT_K]};
                    end
                    else if ((c_pos == PW'(2)) && c_ext[EXT_I] && data_byte[PID_M])
                        dlen_next = c_dlen + 3'd1;
                end
                else if ((c_act == ACT_START) || (c_act == ACT_APPEND))
                begin
                    if (32'(wr_idx) < 32'(FRAME_BYTES))
                        mem_we = 1'b1;
                    else
                        ovf_next = 1'b1;
                end
            end

            if (packet_last)
            begin
                in_pkt_next = 1'b0;
                res_valid   = 1'b1;
                fill_sum    = IW'(base) + IW'(pos_next - PW'(dlen_next));
                if (too_long_next || (pos_next < PW'(dlen_next)))
                    res_status = ST_INVALID;
                else if (act_next == ACT_IGNORE)
                    res_status = ST_MORE;
                else if (act_next == ACT_RESET)
                begin
                    collecting_next = 1'b0;
                    fill_next       = '0;
                    res_status      = ST_MORE;
                end
                else if (ovf_next)
                begin
                    collecting_next = 1'b0;
                    fill_next       = '0;
                    res_status      = ST_OVERFLOW;
                end
                else
                begin
                    fill_next = LW'(fill_sum);
                    if (act_next == ACT_START)
                    begin
                        frame_ts_next   = pend_ts_next;
                        collecting_next = 1'b1;
                    end
                    if (rtp_marker)
                    begin
                        committed_next  = LW'(fill_sum);
                        collecting_next = 1'b0;
                        fill_next       = '0;
                        res_status      = ST_DONE;
                        res_len         = LEN_W'(LW'(fill_sum));
                        res_key         = !desc_next[DESC_N];
                    end
                    else
                        res_status = ST_MORE;
                end
            end
        end
    end

    always_comb
    begin
        p1_valid_next  = p1_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = p1_valid_reg;
            p1_valid_next  = 1'b0;
        end
        if (in_fire && res_valid)
            p1_valid_next = 1'b1;
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= data_byte;
        if (mem_re)
            mem_q <= mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_reg  <= '0;
            fill_reg       <= '0;
            collecting_reg <= 1'b0;
            frame_ts_reg   <= '0;
            pend_ts_reg    <= '0;
            pos_reg        <= '0;
            desc_reg       <= '0;
            ext_reg        <= '0;
            dlen_reg       <= 3'd1;
            act_reg        <= ACT_IGNORE;
            ovf_reg        <= 1'b0;
            in_pkt_reg     <= 1'b0;
            too_long_reg   <= 1'b0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            committed_reg  <= committed_next;
            fill_reg       <= fill_next;
            collecting_reg <= collecting_next;
            frame_ts_reg   <= frame_ts_next;
            pend_ts_reg    <= pend_ts_next;
            pos_reg        <= pos_next;
            desc_reg       <= desc_next;
            ext_reg        <= ext_next;
            dlen_reg       <= dlen_next;
            act_reg        <= act_next;
            ovf_reg        <= ovf_next;
            in_pkt_reg     <= in_pkt_next;
            too_long_reg   <= too_long_next;
            p1_valid_reg   <= p1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            p1_status_reg <= res_status;
            p1_len_reg    <= res_len;
            p1_key_reg    <= res_key;
            p1_rdok_reg   <= res_rdok;
        end
        if (out_load && p1_valid_reg)
        begin
            out_status_reg <= p1_status_reg;
            out_len_reg    <= p1_len_reg;
            out_key_reg    <= p1_key_reg;
            out_rd_reg     <= p1_rdok_reg ? mem_q : 8'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign frame_bytes = out_len_reg;
    assign keyframe    = out_key_reg;
    assign read_data   = out_rd_reg;

endmodule

>>> design/vrd_checker.sv
module vrd_checker
    import vrd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic [STATUS_W-1:0] status,
    input logic [LEN_W-1:0]    frame_bytes,
    input logic                keyframe,
    input logic [7:0]          read_data
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input is only held back when the output side is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    a_key_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && keyframe |-> status == ST_DONE)
        else $error("keyframe flag without completed frame");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> (read_data == 8'd0) && (frame_bytes == '0))
        else $error("data on a failed request");

endmodule

bind vp8_rtp_depacketizer_top vrd_checker u_vrd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .frame_bytes (frame_bytes),
    .keyframe    (keyframe),
    .read_data   (read_data)
);
